@@ src/dwc_pkg.sv @@
`timescale 1ns / 1ps

package dwc_pkg;

    // Frame and kernel limits.
    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int MAX_DILATION = 8;
    localparam int KTAPS        = 9;

    // Raw register widths.
    localparam int CFG_DIM_BITS = 10;
    localparam int CFG_DIL_BITS = 4;
    localparam int CFG_IDX_BITS = 2;

    // Derived widths for the working copies of the registers and counters.
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int DIL_W    = $clog2(MAX_DILATION + 1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_DILATION * MAX_WIDTH;
    localparam int LINE_AW  = $clog2(LINE_DEPTH);
    localparam int LEN_W    = $clog2(LINE_DEPTH + 1);
    localparam int LAG_W    = $clog2(LINE_DEPTH + MAX_DILATION + 1);
    localparam int TOT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int POS_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + LINE_DEPTH + MAX_DILATION + 1);
    localparam int SR_LEN   = 2 * MAX_DILATION;
    localparam int SR_IW    = $clog2(SR_LEN);
    localparam int ACC_W    = 40;
    localparam int QDEPTH   = 4;

    // Input actions.
    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;
    localparam logic [1:0] ACT_DRAIN  = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIL    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELU   = 2'd3;

    // Working frame parameters, clamped.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIL_W-1:0] dil;
        logic [LEN_W-1:0] line_len;
        logic [LAG_W-1:0] lag;
        logic [TOT_W-1:0] total;
        logic             relu;
    } t_params;

    // One classified beat passed from the front to the back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  tap;
        logic [15:0] wval;
        logic [31:0] bval;
        logic [15:0] samp;
        logic        emit;
        logic        last;
        logic        top_ok;
        logic        bot_ok;
        logic        left_ok;
        logic        right_ok;
    } t_rec;

endpackage

@@ src/dwc_in_if.sv @@
`timescale 1ns / 1ps

interface dwc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [3:0]         tap_index;
    logic signed [15:0] weight_value;
    logic signed [31:0] bias_value;
    logic signed [15:0] pixel;

    modport source (output valid, action, tap_index, weight_value, bias_value, pixel,
                    input ready);
    modport sink   (input valid, action, tap_index, weight_value, bias_value, pixel,
                    output ready);
endinterface

@@ src/dwc_out_if.sv @@
`timescale 1ns / 1ps

interface dwc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_pixel;
    logic               frame_last;

    modport source (output valid, out_pixel, frame_last, input ready);
    modport sink   (input valid, out_pixel, frame_last, output ready);
endinterface

@@ src/dwc_front.sv @@
`timescale 1ns / 1ps

module dwc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dwc_in_if.sink           i_in_ch,
    input  dwc_pkg::t_params i_par,
    input  logic             i_restart,
    input  logic             i_full,
    output logic             o_push,
    output dwc_pkg::t_rec    o_rec
);
    import dwc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic [COL_W-1:0] r_ocol, n_ocol;
    logic             w_acc;
    logic             w_stream;
    logic             w_emit;
    logic             w_last;
    logic [DIM_W-1:0] w_hm1;
    logic [DIM_W-1:0] w_wm1;

    assign i_in_ch.ready = !i_full;
    assign w_acc    = i_in_ch.valid && !i_full;
    assign w_stream = (i_in_ch.action == ACT_PIXEL) || (i_in_ch.action == ACT_DRAIN);

    // Output position bookkeeping for the current stream beat.
    assign w_emit = r_pos >= POS_W'(i_par.lag);
    assign w_hm1  = i_par.height - DIM_W'(1);
    assign w_wm1  = i_par.width - DIM_W'(1);
    assign w_last = w_emit && (r_orow == w_hm1[ROW_W-1:0]) && (r_ocol == w_wm1[COL_W-1:0]);

    // Classify the beat; drains and pixels past the frame become zero samples.
    always_comb begin
        o_rec.kind = i_in_ch.action;
        if (w_stream) begin
            o_rec.kind = ACT_PIXEL;
        end
        o_rec.tap  = i_in_ch.tap_index;
        o_rec.wval = i_in_ch.weight_value;
        o_rec.bval = i_in_ch.bias_value;
        o_rec.samp = ((i_in_ch.action == ACT_PIXEL) && (r_pos < POS_W'(i_par.total)))
                     ? i_in_ch.pixel : 16'd0;
        o_rec.emit     = w_emit;
        o_rec.last     = w_last;
        o_rec.top_ok   = r_orow >= ROW_W'(i_par.dil);
        o_rec.bot_ok   = (DIM_W'(r_orow) + DIM_W'(i_par.dil)) < i_par.height;
        o_rec.left_ok  = r_ocol >= COL_W'(i_par.dil);
        o_rec.right_ok = (DIM_W'(r_ocol) + DIM_W'(i_par.dil)) < i_par.width;
    end

    assign o_push = w_acc;

    // Next counter values.
    always_comb begin
        n_pos  = r_pos;
        n_orow = r_orow;
        n_ocol = r_ocol;
        if (i_restart) begin
            n_pos  = '0;
            n_orow = '0;
            n_ocol = '0;
        end else if (w_acc && w_stream) begin
            n_pos = r_pos + POS_W'(1);
            if (w_last) begin
                n_pos  = '0;
                n_orow = '0;
                n_ocol = '0;
            end else if (w_emit) begin
                if (r_ocol == w_wm1[COL_W-1:0]) begin
                    n_ocol = '0;
                    n_orow = r_orow + ROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_orow <= '0;
            r_ocol <= '0;
        end else begin
            r_pos  <= n_pos;
            r_orow <= n_orow;
            r_ocol <= n_ocol;
        end
    end

endmodule

@@ src/dwc_queue.sv @@
`timescale 1ns / 1ps

module dwc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dwc_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output dwc_pkg::t_rec o_rec,
    output logic          o_empty
);
    import dwc_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = r_cnt == QCW'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    // The fill count never passes the depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue count above depth");

    // The pointers stay apart by the fill count; this check covers the empty and full cases.
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == QCW'(QDEPTH)) |-> (r_wr == r_rd))
        else $error("queue pointers out of step");

endmodule

@@ src/dwc_back.sv @@
`timescale 1ns / 1ps

module dwc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dwc_pkg::t_params i_par,
    input  logic             i_restart,
    input  logic             i_empty,
    input  dwc_pkg::t_rec    i_rec,
    output logic             o_pop,
    dwc_out_if.source        o_out_ch
);
    import dwc_pkg::*;

    // Two row delay lines, each d*W beats long.
    logic [15:0]        r_line1 [LINE_DEPTH];
    logic [15:0]        r_line2 [LINE_DEPTH];
    logic [LINE_AW-1:0] r_p1;
    logic [LINE_AW-1:0] r_p2;
    logic [15:0]        r_rd1;
    logic [15:0]        r_rd2;

    // Column taps of the three row streams.
    logic [15:0] r_sr_a [SR_LEN];
    logic [15:0] r_sr_b [SR_LEN];
    logic [15:0] r_sr_c [SR_LEN];

    logic [KTAPS-1:0][15:0] r_w;
    logic [31:0]            r_bias;

    logic        en;
    logic        w_pop;
    logic        r1_v, r2_v, r3_v, r4_v, r5_v, r_out_v;
    t_rec        r1, r2;
    logic [15:0] r2_s1;

    logic [KTAPS-1:0][31:0]  r3_p;
    logic [31:0]             r3_bias;
    logic                    r3_last, r3_relu;
    logic signed [ACC_W-1:0] r4_g0, r4_g1, r4_g2;
    logic                    r4_last, r4_relu;
    logic signed [ACC_W-1:0] r5_acc;
    logic                    r5_last, r5_relu;
    logic [15:0]             r_out_pix;
    logic                    r_out_last, r_out_relu;

    logic                   w_s1_samp;
    logic                   w_s2_samp;
    logic [SR_IW-1:0]       w_i1;
    logic [SR_IW-1:0]       w_i2;
    logic [DIL_W:0]         w_d2;
    logic [2:0][2:0][15:0]  w_win;
    logic [2:0]             w_okr, w_okc;
    logic [KTAPS-1:0][31:0] w_prod;

    logic signed [ACC_W-1:0]  w_act;
    logic signed [ACC_W:0]    w_rnd;
    logic signed [ACC_W-14:0] w_q;
    logic [15:0]              w_sat;

    // The whole back stalls only while a finished result waits.
    assign en       = !r_out_v || o_out_ch.ready;
    assign w_pop    = en && !i_empty;
    assign o_pop    = w_pop;
    assign w_s1_samp = w_pop && (i_rec.kind == ACT_PIXEL);
    assign w_s2_samp = en && r1_v && (r1.kind == ACT_PIXEL);

    // Delay line storage: read the oldest beat, write the newest in its place.
    always_ff @(posedge i_clk) begin
        if (w_s1_samp) begin
            r_rd1        <= r_line1[r_p1];
            r_line1[r_p1] <= i_rec.samp;
        end
        if (w_s2_samp) begin
            r_rd2        <= r_line2[r_p2];
            r_line2[r_p2] <= r_rd1;
        end
    end

    // Delay line pointers wrap at d*W.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_p1 <= '0;
            r_p2 <= '0;
        end else begin
            if (w_s1_samp) begin
                r_p1 <= (LEN_W'(r_p1) == i_par.line_len - LEN_W'(1)) ? '0 : r_p1 + LINE_AW'(1);
            end
            if (w_s2_samp) begin
                r_p2 <= (LEN_W'(r_p2) == i_par.line_len - LEN_W'(1)) ? '0 : r_p2 + LINE_AW'(1);
            end
        end
    end

    // Window taps: row 0 is the oldest stream, column 0 the oldest beat.
    assign w_d2 = {i_par.dil, 1'b0} - (DIL_W + 1)'(1);
    assign w_i1 = SR_IW'(i_par.dil - DIL_W'(1));
    assign w_i2 = w_d2[SR_IW-1:0];

    always_comb begin
        w_win[0][2] = r_rd2;
        w_win[0][1] = r_sr_c[w_i1];
        w_win[0][0] = r_sr_c[w_i2];
        w_win[1][2] = r2_s1;
        w_win[1][1] = r_sr_b[w_i1];
        w_win[1][0] = r_sr_b[w_i2];
        w_win[2][2] = r2.samp;
        w_win[2][1] = r_sr_a[w_i1];
        w_win[2][0] = r_sr_a[w_i2];
        w_okr = {r2.bot_ok, 1'b1, r2.top_ok};
        w_okc = {r2.right_ok, 1'b1, r2.left_ok};
    end

    // Tap products; taps outside the frame count as zero.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_prod[i*3+j] = (w_okr[i] && w_okc[j])
                    ? 32'($signed(w_win[i][j]) * $signed(r_w[i*3+j])) : 32'd0;
            end
        end
    end

    // Relu, round half up to Q8.8 and saturate.
    always_comb begin
        w_act = (r5_relu && r5_acc[ACC_W-1]) ? '0 : r5_acc;
        w_rnd = {w_act[ACC_W-1], w_act} + (ACC_W + 1)'(8192);
        w_q   = w_rnd[ACC_W:14];
        if (!w_q[ACC_W-14] && (|w_q[ACC_W-15:15])) begin
            w_sat = 16'h7FFF;
        end else if (w_q[ACC_W-14] && !(&w_q[ACC_W-15:15])) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_q[15:0];
        end
    end

    // Stage valid bits, kernel state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r_out_v <= 1'b0;
            r_w     <= '0;
            r_bias  <= '0;
        end else if (en) begin
            r1_v    <= w_pop;
            r2_v    <= r1_v;
            r3_v    <= r2_v && (r2.kind == ACT_PIXEL) && r2.emit;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_out_v <= r5_v;
            if (r2_v && (r2.kind == ACT_WEIGHT) && (r2.tap < 4'(KTAPS))) begin
                r_w[r2.tap] <= r2.wval;
            end
            if (r2_v && (r2.kind == ACT_BIAS)) begin
                r_bias <= r2.bval;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1    <= i_rec;
            r2    <= r1;
            r2_s1 <= r_rd1;
            if (r2_v && (r2.kind == ACT_PIXEL)) begin
                r_sr_a[0] <= r2.samp;
                r_sr_b[0] <= r2_s1;
                r_sr_c[0] <= r_rd2;
                for (int k = 1; k < SR_LEN; k++) begin
                    r_sr_a[k] <= r_sr_a[k-1];
                    r_sr_b[k] <= r_sr_b[k-1];
                    r_sr_c[k] <= r_sr_c[k-1];
                end
            end
            r3_p    <= w_prod;
            r3_bias <= r_bias;
            r3_last <= r2.last;
            r3_relu <= i_par.relu;
            r4_g0   <= ACC_W'($signed(r3_p[0])) + ACC_W'($signed(r3_p[1]))
                     + ACC_W'($signed(r3_p[2])) + ACC_W'($signed(r3_p[3]));
            r4_g1   <= ACC_W'($signed(r3_p[4])) + ACC_W'($signed(r3_p[5]))
                     + ACC_W'($signed(r3_p[6])) + ACC_W'($signed(r3_p[7]));
            r4_g2   <= ACC_W'($signed(r3_p[8])) + ACC_W'($signed(r3_bias));
            r4_last <= r3_last;
            r4_relu <= r3_relu;
            r5_acc  <= r4_g0 + r4_g1 + r4_g2;
            r5_last <= r4_last;
            r5_relu <= r4_relu;
            r_out_pix  <= w_sat;
            r_out_last <= r5_last;
            r_out_relu <= r5_relu;
        end
    end

    assign o_out_ch.valid      = r_out_v;
    assign o_out_ch.out_pixel  = r_out_pix;
    assign o_out_ch.frame_last = r_out_last;

    // Delay line pointers stay inside the programmed line length.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_p1) < i_par.line_len) && (LEN_W'(r_p2) < i_par.line_len))
        else $error("delay line pointer past line length");

    // A result made with relu on is never negative.
    a_relu_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_relu) |-> !r_out_pix[15])
        else $error("negative result with relu");

    // A weight load with a tap index past the kernel changes nothing.
    a_bad_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r2_v && (r2.kind == ACT_WEIGHT) && (r2.tap >= 4'(KTAPS))) |=> $stable(r_w))
        else $error("weights changed by out of range tap");

endmodule

@@ src/depthwise_conv3x3_dilated_core.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Handshake      Payload
// i_in_ch    in   valid / ready  action, tap_index, weight_value, bias_value, pixel
// o_out_ch   out  valid / ready  out_pixel, frame_last
// i_cfg_*    in   write enable   i_cfg_idx selects the register, i_cfg_data holds it
//
// One beat per cycle is taken while results are taken at the output; the back is fully pipelined and
// each row delay line uses one read and one write port per beat.
// After its beat is accepted, a result passes through the queue and back stages r1 to r5 to the output register.
// Reset is synchronous and active low; it clears counters, weights and bias and loads the register defaults.
// A four entry queue lets the input keep running while a result waits.

module depthwise_conv3x3_dilated_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dwc_in_if.sink                           i_in_ch,
    dwc_out_if.source                        o_out_ch,
    input  logic                             i_cfg_we,
    input  logic [dwc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [dwc_pkg::CFG_DIM_BITS-1:0] i_cfg_data
);
    import dwc_pkg::*;

    logic [CFG_DIM_BITS-1:0] r_fw, n_fw;
    logic [CFG_DIM_BITS-1:0] r_fh, n_fh;
    logic [CFG_DIL_BITS-1:0] r_dil, n_dil;
    logic                    r_relu, n_relu;
    t_params                 r_par, n_par;

    logic [DIM_W-1:0] w_wc, w_hc, w_sm, w_dmax;
    logic [DIL_W-1:0] w_dc, w_d;

    logic push, pop, full, empty;
    t_rec rec_in, rec_out;

    // Register writes; during reset the next values are the reset values.
    always_comb begin
        n_fw   = r_fw;
        n_fh   = r_fh;
        n_dil  = r_dil;
        n_relu = r_relu;
        if (!i_rst_n) begin
            n_fw   = CFG_DIM_BITS'(64);
            n_fh   = CFG_DIM_BITS'(64);
            n_dil  = CFG_DIL_BITS'(1);
            n_relu = 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  n_fw   = i_cfg_data;
                CFG_HEIGHT: n_fh   = i_cfg_data;
                CFG_DIL:    n_dil  = i_cfg_data[CFG_DIL_BITS-1:0];
                CFG_RELU:   n_relu = i_cfg_data[0];
                default:    n_fw   = r_fw;
            endcase
        end
    end

    // Clamp the registers to the working frame parameters.
    always_comb begin
        if (DIM_W'(n_fw) < DIM_W'(4)) begin
            w_wc = DIM_W'(4);
        end else if (DIM_W'(n_fw) > DIM_W'(MAX_WIDTH)) begin
            w_wc = DIM_W'(MAX_WIDTH);
        end else begin
            w_wc = DIM_W'(n_fw);
        end
        if (DIM_W'(n_fh) < DIM_W'(4)) begin
            w_hc = DIM_W'(4);
        end else if (DIM_W'(n_fh) > DIM_W'(MAX_HEIGHT)) begin
            w_hc = DIM_W'(MAX_HEIGHT);
        end else begin
            w_hc = DIM_W'(n_fh);
        end
        w_sm   = (w_wc < w_hc) ? w_wc : w_hc;
        w_dmax = (w_sm - DIM_W'(1)) >> 1;
        if (n_dil == '0) begin
            w_dc = DIL_W'(1);
        end else if (DIL_W'(n_dil) > DIL_W'(MAX_DILATION)) begin
            w_dc = DIL_W'(MAX_DILATION);
        end else begin
            w_dc = DIL_W'(n_dil);
        end
        w_d = (DIM_W'(w_dc) > w_dmax) ? DIL_W'(w_dmax) : w_dc;

        n_par.width    = w_wc;
        n_par.height   = w_hc;
        n_par.dil      = w_d;
        n_par.line_len = LEN_W'(LEN_W'(w_d) * LEN_W'(w_wc));
        n_par.lag      = LAG_W'(n_par.line_len) + LAG_W'(w_d);
        n_par.total    = TOT_W'(TOT_W'(w_wc) * TOT_W'(w_hc));
        n_par.relu     = n_relu;
    end

    always_ff @(posedge i_clk) begin
        r_fw   <= n_fw;
        r_fh   <= n_fh;
        r_dil  <= n_dil;
        r_relu <= n_relu;
        r_par  <= n_par;
    end

    dwc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_ch   (i_in_ch),
        .i_par     (r_par),
        .i_restart (i_cfg_we),
        .i_full    (full),
        .o_push    (push),
        .o_rec     (rec_in)
    );

    dwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (rec_out),
        .o_empty (empty)
    );

    dwc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_par     (r_par),
        .i_restart (i_cfg_we),
        .i_empty   (empty),
        .i_rec     (rec_out),
        .o_pop     (pop),
        .o_out_ch  (o_out_ch)
    );

endmodule
